// File: rtl/core/plateau_level_tracker_macros.svh
// -----------------------------------------------------------------------------
// plateau_level_tracker_macros
// Assertion shorthands used by the plateau level tracker RTL.
// -----------------------------------------------------------------------------
`ifndef PLATEAU_LEVEL_TRACKER_MACROS_SVH
`define PLATEAU_LEVEL_TRACKER_MACROS_SVH

// Check on every clock edge outside reset.
`define PLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PLT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/plt_pkg.sv
// -----------------------------------------------------------------------------
// plt_pkg
// Shared widths, register codes and result type of the plateau level tracker.
// -----------------------------------------------------------------------------
package plt_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TOL_W      = 16;
    localparam int NUM_W      = 10;
    localparam int WINDOW_DEF = 8;

    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    localparam logic [TOL_W-1:0] LEVEL_TOL_RST  = TOL_W'(64);
    localparam logic [TOL_W-1:0] CHANGE_TOL_RST = TOL_W'(32);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register select, taken from paddr[2]
    localparam logic REG_LEVEL_TOL  = 1'b0;
    localparam logic REG_CHANGE_TOL = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level;
        logic [NUM_W-1:0]           level_number;
        logic                       new_level;
    } t_result;

endpackage

// File: rtl/core/plt_window.sv
// -----------------------------------------------------------------------------
// plt_window
// Shift line of recent samples with parallel change-tolerance compares.
// -----------------------------------------------------------------------------
module plt_window #(
    parameter int WINDOW = plt_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_clear,
    input  logic signed [plt_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [plt_pkg::TOL_W-1:0]           i_change_tol,
    output logic                                o_steady
);

    localparam int CNT_W = $clog2(WINDOW + 1);

    logic signed [plt_pkg::SAMPLE_W-1:0] r_taps [WINDOW];
    logic [CNT_W-1:0]                    r_count;
    logic [CNT_W-1:0]                    n_count;
    logic [WINDOW-1:0]                   w_ok;

    // Per-tap distance check; taps beyond the fill count do not vote
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            logic signed [plt_pkg::SAMPLE_W:0] diff;
            logic [plt_pkg::SAMPLE_W:0]        mag;
            diff = {i_sample[plt_pkg::SAMPLE_W-1], i_sample}
                 - {r_taps[i][plt_pkg::SAMPLE_W-1], r_taps[i]};
            mag  = diff[plt_pkg::SAMPLE_W] ? (plt_pkg::SAMPLE_W+1)'(-diff)
                                           : (plt_pkg::SAMPLE_W+1)'(diff);
            w_ok[i] = (CNT_W'(i) >= r_count) || (mag <= {1'b0, i_change_tol});
        end
    end

    assign o_steady = (r_count != '0) && (&w_ok);

    always_comb begin
        if (i_clear) begin
            n_count = CNT_W'(1);
        end else if (r_count < CNT_W'(WINDOW)) begin
            n_count = r_count + CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_push) begin
            r_count <= n_count;
        end
    end

    // Advance the shift line; newest sample at tap 0
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_taps[0] <= i_sample;
            for (int i = 1; i < WINDOW; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
    end

endmodule

// File: rtl/core/plt_level.sv
// -----------------------------------------------------------------------------
// plt_level
// Current level and plateau count, with the merge / open decision.
// -----------------------------------------------------------------------------
module plt_level (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic signed [plt_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_first,
    input  logic [plt_pkg::TOL_W-1:0]           i_level_tol,
    input  logic                                i_steady,
    output plt_pkg::t_result                    o_res,
    output logic [plt_pkg::NUM_W-1:0]           o_count
);

    localparam int EXT_W = plt_pkg::SAMPLE_W + 2;

    logic signed [plt_pkg::SAMPLE_W-1:0] r_level;
    logic [plt_pkg::NUM_W-1:0]           r_count;

    logic signed [EXT_W-1:0]             w_lvl_x;
    logic signed [EXT_W-1:0]             w_smp_x;
    logic signed [EXT_W-1:0]             w_tol_x;
    logic                                w_in_band;
    logic signed [plt_pkg::SAMPLE_W:0]   w_sum;
    logic signed [plt_pkg::SAMPLE_W:0]   w_half;

    assign w_lvl_x = {{2{r_level[plt_pkg::SAMPLE_W-1]}}, r_level};
    assign w_smp_x = {{2{i_sample[plt_pkg::SAMPLE_W-1]}}, i_sample};
    assign w_tol_x = {2'b00, i_level_tol};

    assign w_in_band = (w_smp_x > (w_lvl_x - w_tol_x)) && (w_smp_x < (w_lvl_x + w_tol_x));

    // Floor of the mean: arithmetic shift of the widened sum
    assign w_sum  = {r_level[plt_pkg::SAMPLE_W-1], r_level}
                  + {i_sample[plt_pkg::SAMPLE_W-1], i_sample};
    assign w_half = w_sum >>> 1;

    always_comb begin
        o_res.level        = r_level;
        o_res.level_number = r_count;
        o_res.new_level    = 1'b0;
        if (i_first) begin
            o_res.level        = i_sample;
            o_res.level_number = '0;
            o_res.new_level    = 1'b1;
        end else if (w_in_band) begin
            o_res.level = w_half[plt_pkg::SAMPLE_W-1:0];
        end else if (i_steady) begin
            o_res.level     = i_sample;
            o_res.new_level = 1'b1;
            if (r_count != plt_pkg::NUM_MAX) begin
                o_res.level_number = r_count + plt_pkg::NUM_W'(1);
            end
        end
    end

    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_level <= o_res.level;
            r_count <= o_res.level_number;
        end
    end

endmodule

// File: rtl/core/plateau_level_tracker.sv
// -----------------------------------------------------------------------------
// plateau_level_tracker: flat-level finder over a signed 16-bit sample stream.
// Pipeline: each sample passes the input register and then the result register.
// Throughput: 1 sample per cycle unless the result stream stalls; the level,
// count and window update in one pass, on the edge that loads the result reg.
// Reset: synchronous active-low; clears level, count, window fill and pipeline.
// -----------------------------------------------------------------------------
`include "plateau_level_tracker_macros.svh"

module plateau_level_tracker #(
    parameter int WINDOW = plt_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // [15:0] sample
    input  logic                              s_axis_tuser,   // [0] first

    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [15:0] level,
                                                              // [25:16] level_number
    output logic                              m_axis_tuser,   // [0] new_level

    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [plt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [plt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [plt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    // -------------------------------------------------------------------------
    // Configuration registers. paddr[2] selects the register; the low bits
    // are ignored so every write lands on one of the two tolerances.
    // -------------------------------------------------------------------------
    logic [plt_pkg::TOL_W-1:0] r_level_tol;
    logic [plt_pkg::TOL_W-1:0] r_change_tol;
    logic                      w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_tol  <= plt_pkg::LEVEL_TOL_RST;
            r_change_tol <= plt_pkg::CHANGE_TOL_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                plt_pkg::REG_LEVEL_TOL:  r_level_tol  <= pwdata[plt_pkg::TOL_W-1:0];
                plt_pkg::REG_CHANGE_TOL: r_change_tol <= pwdata[plt_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            plt_pkg::REG_LEVEL_TOL:  prdata = {{(plt_pkg::APB_DATA_W-plt_pkg::TOL_W){1'b0}},
                                               r_level_tol};
            plt_pkg::REG_CHANGE_TOL: prdata = {{(plt_pkg::APB_DATA_W-plt_pkg::TOL_W){1'b0}},
                                               r_change_tol};
            default:                 prdata = '0;
        endcase
    end

    // -------------------------------------------------------------------------
    // Pipeline control. The result register frees up when empty or taken;
    // the input register may then hand its sample on, and a new sample may
    // enter whenever the input register is empty or moving on.
    // -------------------------------------------------------------------------
    logic                                r_s1_vld;
    logic signed [plt_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                                r_s1_first;
    logic                                r_out_vld;
    plt_pkg::t_result                    r_out_res;

    logic                                w_out_free;
    logic                                w_fire;
    logic                                w_accept;
    logic                                n_s1_vld;
    logic                                w_steady;
    plt_pkg::t_result                    w_res;
    logic [plt_pkg::NUM_W-1:0]           w_count;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_fire        = r_s1_vld && w_out_free;
    assign s_axis_tready = !r_s1_vld || w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign n_s1_vld      = w_accept || (r_s1_vld && !w_out_free);

    // Capture the incoming sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= s_axis_tdata[plt_pkg::SAMPLE_W-1:0];
            r_s1_first  <= s_axis_tuser;
        end
    end

    // -------------------------------------------------------------------------
    // Single-pass update: window steadiness and level decision both see the
    // registered sample; tracker state advances on the same edge that loads
    // the result register.
    // -------------------------------------------------------------------------
    plt_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_fire),
        .i_clear      (r_s1_first),
        .i_sample     (r_s1_sample),
        .i_change_tol (r_change_tol),
        .o_steady     (w_steady)
    );

    plt_level u_level (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_sample    (r_s1_sample),
        .i_first     (r_s1_first),
        .i_level_tol (r_level_tol),
        .i_steady    (w_steady),
        .o_res       (w_res),
        .o_count     (w_count)
    );

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b000000, r_out_res.level_number, r_out_res.level};
    assign m_axis_tuser  = r_out_res.new_level;

    // -------------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------------
    `PLT_ASSERT_ALWAYS(a_rst_flush, !i_rst_n |=> !m_axis_tvalid && !r_s1_vld,
        "pipeline not flushed by reset")
    `PLT_ASSERT(a_s1_hold, r_s1_vld && !w_out_free |=> r_s1_vld,
        "staged sample dropped while result stalled")
    `PLT_ASSERT(a_count_step, w_fire && !r_s1_first |->
        (w_res.level_number == w_count) || (w_res.level_number == w_count + 10'd1),
        "plateau count moved by more than one")
    `PLT_ASSERT(a_open_level, w_fire && w_res.new_level |-> w_res.level == r_s1_sample,
        "opened plateau does not start at the sample")

endmodule
